### sv/sma_pkg.sv
`default_nettype none

package sma_pkg;

  localparam int WINDOW_MAX    = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int POSITION_BITS = 20;
  localparam int LEN_BITS      = 7;
  localparam int SLOT_BITS     = $clog2(WINDOW_MAX);
  localparam int TOTAL_BITS    = 22;
  localparam int CENTRE_BITS   = POSITION_BITS + 1;
  localparam int STEP_BITS     = $clog2(TOTAL_BITS + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [TOTAL_BITS-1:0]  total_t;
  typedef logic [LEN_BITS-1:0]           len_t;
  typedef logic [SLOT_BITS-1:0]          slot_t;

  // ring memory access for one cycle
  typedef struct packed {
    logic    rd_en;
    slot_t   rd_addr;
    logic    wr_en;
    slot_t   wr_addr;
    sample_t wr_data;
  } ring_req_t;

  // divider launch
  typedef struct packed {
    logic   start;
    total_t dividend;
    len_t   divisor;
  } div_req_t;

  // divider result, held until the next launch
  typedef struct packed {
    logic    done;
    sample_t quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### sv/sma_in_if.sv
`default_nettype none

interface sma_in_if
  import sma_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

### sv/sma_out_if.sv
`default_nettype none

interface sma_out_if
  import sma_pkg::*;
;
  logic                   valid;
  logic                   ready;
  sample_t                mean;
  logic [CENTRE_BITS-1:0] centre_twice;

  modport source (output valid, output mean, output centre_twice, input ready);
  modport sink (input valid, input mean, input centre_twice, output ready);
endinterface

`default_nettype wire

### sv/sma_ring.sv
`default_nettype none

module sma_ring
  import sma_pkg::*;
(
  input  wire       clk,
  input  ring_req_t req,
  output sample_t   rd_data
);

  sample_t mem [WINDOW_MAX];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/sma_div.sv
`default_nettype none

module sma_div
  import sma_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic                  done;
  logic [STEP_BITS-1:0]  count;
  logic [LEN_BITS-1:0]   rem;
  logic [TOTAL_BITS-1:0] quot;
  logic                  neg;
  len_t                  divisor;

  logic [LEN_BITS:0]     rem_shift;
  logic                  fits;
  logic [LEN_BITS-1:0]   rem_next;
  logic [TOTAL_BITS-1:0] magnitude;
  logic [TOTAL_BITS-1:0] signed_quot;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_shift = {rem, quot[TOTAL_BITS-1]};
    fits      = rem_shift >= {1'b0, divisor};
    if (fits) begin
      rem_next = LEN_BITS'(rem_shift - {1'b0, divisor});
    end else begin
      rem_next = rem_shift[LEN_BITS-1:0];
    end
    magnitude   = req.dividend[TOTAL_BITS-1] ? TOTAL_BITS'(-req.dividend)
                                             : TOTAL_BITS'(req.dividend);
    signed_quot = neg ? TOTAL_BITS'(-quot) : quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && count == STEP_BITS'(1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      count   <= STEP_BITS'(TOTAL_BITS);
      rem     <= '0;
      quot    <= magnitude;
      neg     <= req.dividend[TOTAL_BITS-1];
      divisor <= req.divisor;
    end else if (busy) begin
      count <= count - STEP_BITS'(1);
      rem   <= rem_next;
      quot  <= {quot[TOTAL_BITS-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = signed_quot[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

### sv/simple_moving_average.sv
// simple moving average (boxcar) over the last window_len Q7.8 samples, 1 to 64. each
// accepted request writes its sample into a 64-entry ring memory and updates a running
// sum; once window_len samples have arrived since reset or the last window_len write,
// every request yields one result: the window mean truncated toward zero and twice the
// window centre index (2i - n + 1, i = index of the newest sample, wrapping at 20 bits).
// a request that completes a result goes through the ring read at acceptance, the sum
// update and ring write, the serial divider (one quotient bit per cycle) and the load of
// the output register before the next acceptance. requests that only fill the window
// return to idle after the update step. the result sits in an output register, so the
// next request is taken while it waits; a second result waits in the divider until the
// first is taken. writing window_len clears the sum and fill count, but keeps the sample
// index; a length of 0 acts as 1, above 64 as 64. configuration must be written only
// while the block is idle; the block itself does not enforce it.
`default_nettype none

module simple_moving_average
  import sma_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  sma_in_if.sink     samples,
  sma_out_if.source  averages,
  input  wire        cfg_we,
  input  wire len_t  cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_UPDATE = 3'b010,
    S_DIV    = 3'b100
  } state_t;

  state_t                   state;
  state_t                   state_next;

  // control and window state
  len_t                     window_len;
  slot_t                    write_slot;
  total_t                   running_total;
  len_t                     filled_count;
  logic [POSITION_BITS-1:0] sample_position;

  // per-request hold registers
  sample_t                  x_hold;
  len_t                     n_hold;
  logic                     evict_hold;
  logic [CENTRE_BITS-1:0]   centre_hold;

  // output register
  logic                     out_valid;
  sample_t                  out_mean;
  logic [CENTRE_BITS-1:0]   out_centre;

  ring_req_t                ring_req;
  sample_t                  ring_rd_data;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  len_t                     n_eff;
  logic                     accept;
  logic                     out_free;
  total_t                   old_ext;
  total_t                   total_next;
  len_t                     filled_next;
  logic                     produce;

  sma_ring u_ring (
    .clk     (clk),
    .req     (ring_req),
    .rd_data (ring_rd_data)
  );

  sma_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // clamp the configured length into 1..WINDOW_MAX
  always_comb begin
    if (window_len == '0) begin
      n_eff = LEN_BITS'(1);
    end else if (window_len > LEN_BITS'(WINDOW_MAX)) begin
      n_eff = LEN_BITS'(WINDOW_MAX);
    end else begin
      n_eff = window_len;
    end
  end

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign out_free      = !out_valid || averages.ready;

  // update step: drop the oldest sample when the window is full, add the new one
  always_comb begin
    old_ext     = TOTAL_BITS'(ring_rd_data);
    total_next  = running_total + TOTAL_BITS'(x_hold);
    filled_next = filled_count;
    if (evict_hold) begin
      total_next = total_next - old_ext;
    end else begin
      filled_next = filled_count + LEN_BITS'(1);
    end
    produce = filled_next >= n_hold;
  end

  // ring access: read the oldest slot at acceptance, write the new sample in the next cycle
  always_comb begin
    ring_req.rd_en   = accept;
    ring_req.rd_addr = write_slot - n_eff[SLOT_BITS-1:0];
    ring_req.wr_en   = (state == S_UPDATE);
    ring_req.wr_addr = write_slot;
    ring_req.wr_data = x_hold;
  end

  always_comb begin
    div_req.start    = (state == S_UPDATE) && produce;
    div_req.dividend = total_next;
    div_req.divisor  = n_hold;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = produce ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (div_rsp.done && out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      window_len      <= LEN_BITS'(1);
      write_slot      <= '0;
      running_total   <= '0;
      filled_count    <= '0;
      sample_position <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        // new length restarts the fill, index and ring are kept
        window_len    <= cfg_wdata;
        running_total <= '0;
        filled_count  <= '0;
      end else if (state == S_UPDATE) begin
        running_total   <= total_next;
        filled_count    <= filled_next;
        write_slot      <= write_slot + SLOT_BITS'(1);
        sample_position <= sample_position + POSITION_BITS'(1);
      end
    end
  end

  // capture the request and what the update step needs
  always_ff @(posedge clk) begin
    if (accept) begin
      x_hold      <= samples.sample;
      n_hold      <= n_eff;
      evict_hold  <= filled_count >= n_eff;
      centre_hold <= {sample_position, 1'b1} - CENTRE_BITS'(n_eff);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DIV && div_rsp.done && out_free) begin
      out_valid <= 1'b1;
    end else if (averages.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DIV && div_rsp.done && out_free) begin
      out_mean   <= div_rsp.quotient;
      out_centre <= centre_hold;
    end
  end

  assign averages.valid        = out_valid;
  assign averages.mean         = out_mean;
  assign averages.centre_twice = out_centre;

endmodule

`default_nettype wire

### tb/sma_checker.sv
`timescale 1ns / 1ps

module sma_checker
  import sma_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  sma_in_if         samples,
  sma_out_if        averages,
  input  wire       cfg_we,
  input  wire len_t cfg_wdata,
  output int        mismatch_count,
  output int        outstanding
);

  typedef struct packed {
    sample_t                mean;
    logic [CENTRE_BITS-1:0] centre_twice;
  } average_t;

  // shadow copy of the filter state
  sample_t                  history [WINDOW_MAX];
  slot_t                    next_slot;
  int                       window_sum;
  int                       fill_level;
  logic [POSITION_BITS-1:0] next_index;
  len_t                     window_reg;

  average_t expected_averages [$];

  // zero acts as one, anything past the ring depth as the full ring
  function automatic int span(input len_t len);
    if (len == 0) return 1;
    if (len > WINDOW_MAX) return WINDOW_MAX;
    return int'(len);
  endfunction

  function automatic bit take_sample(input sample_t s, output average_t avg);
    int n;
    n = span(window_reg);
    if (fill_level >= n) begin
      window_sum -= history[slot_t'(next_slot - slot_t'(n))];
    end else begin
      fill_level++;
    end
    history[next_slot] = s;
    window_sum += s;
    next_slot = next_slot + slot_t'(1);
    avg.mean = sample_t'(window_sum / n);
    avg.centre_twice = {next_index, 1'b0} + 21'd1 - CENTRE_BITS'(n);
    next_index = next_index + POSITION_BITS'(1);
    return fill_level >= n;
  endfunction

  always @(posedge clk) begin : watch
    average_t got;
    average_t want;
    if (rst) begin
      foreach (history[k]) history[k] = '0;
      next_slot = '0;
      window_sum = 0;
      fill_level = 0;
      next_index = '0;
      window_reg = len_t'(1);
      expected_averages.delete();
      mismatch_count = 0;
      outstanding <= 0;
    end else begin
      if (averages.valid && averages.ready) begin
        got.mean = averages.mean;
        got.centre_twice = averages.centre_twice;
        if (expected_averages.size() == 0) begin
          $display("%0t: unexpected result, expected none, got mean %0d centre_twice %0d",
                   $time, $signed(got.mean), got.centre_twice);
          mismatch_count++;
        end else begin
          want = expected_averages.pop_front();
          if (got.mean !== want.mean) begin
            $display("%0t: mean mismatch, expected %0d, got %0d",
                     $time, $signed(want.mean), $signed(got.mean));
            mismatch_count++;
          end
          if (got.centre_twice !== want.centre_twice) begin
            $display("%0t: centre_twice mismatch, expected %0d, got %0d",
                     $time, want.centre_twice, got.centre_twice);
            mismatch_count++;
          end
        end
      end
      // a new length restarts the fill, index and ring are kept
      if (cfg_we) begin
        window_reg = cfg_wdata;
        fill_level = 0;
        window_sum = 0;
      end
      if (samples.valid && samples.ready) begin
        if (take_sample(samples.sample, want)) expected_averages.push_back(want);
      end
      outstanding <= expected_averages.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import sma_pkg::*;

  localparam int MAX_GAP         = 12;     // longest idle stretch per request, either side
  localparam int SETTLE_CYCLES   = 30;     // margin for fill-only requests to finish
  localparam int HOLD_CYCLES     = 300;    // long receiver hold-off to back up the block
  localparam int RANDOM_REQUESTS = 1900;

  logic clk;
  logic rst;
  logic cfg_we;
  len_t cfg_wdata;

  int mismatch_count;
  int outstanding;
  int hold_request;    // receiver hold-off asked by the stimulus, 0 when none
  int sent;            // accepted requests so far
  bit tx_quiet;        // sender runs back to back while set
  bit rx_quiet;        // receiver never stalls while set

  sma_in_if  sample_bus ();
  sma_out_if average_bus ();

  simple_moving_average u_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (sample_bus),
    .averages (average_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // watches both channels and the config port, predicts and compares
  sma_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .samples       (sample_bus),
    .averages      (average_bus),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("[simple_moving_average] ERROR");
    $finish;
  end

  // sample mix: rails, values around zero, anything
  function automatic sample_t random_sample();
    case ($urandom_range(0, 7))
      0: return sample_t'(16'h7FFF);
      1: return sample_t'(16'h8000);
      2: return sample_t'(int'($urandom_range(0, 16)) - 8);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // one request; valid stays up after acceptance so back-to-back requests
  // never drop it, the next call lowers it only if it idles first
  task automatic send_sample(input sample_t s);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= s;
    do @(posedge clk); while (!sample_bus.ready);
    sent++;
  endtask

  // stop sending until every predicted average is out, then let any
  // fill-only request still in flight finish
  task automatic drain();
    sample_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input len_t len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // result side: random stalls per result, quiet stretches, and the long
  // hold-off whenever the stimulus asks for one
  initial begin
    int stall;
    average_bus.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        average_bus.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
      if (stall > 0) begin
        average_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      average_bus.ready <= 1'b1;
      do @(posedge clk); while (!average_bus.valid);
    end
  end

  initial begin
    int   target;
    int   phase;
    int   span_len;
    int   count;
    len_t len;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    sample_bus.valid  = 1'b0;
    sample_bus.sample = '0;
    hold_request     = 0;
    sent             = 0;
    tx_quiet         = 1'b0;
    rx_quiet         = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // window of one straight out of reset: every request is its own mean
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    send_sample(sample_t'(0));

    // length zero behaves as one
    drain();
    set_window(len_t'(0));
    send_sample(sample_t'(16'h7FFF));
    send_sample(sample_t'(16'h8000));

    // window of three: small negative sums truncate toward zero, full-scale sums
    drain();
    set_window(len_t'(3));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(0));
    repeat (3) send_sample(sample_t'(16'h8000));
    repeat (3) send_sample(sample_t'(16'h7FFF));

    // partial fill, then a new length restarts the fill from scratch
    drain();
    set_window(len_t'(4));
    send_sample(sample_t'(100));
    send_sample(sample_t'(200));
    drain();
    set_window(len_t'(2));
    send_sample(sample_t'(5));
    send_sample(sample_t'(-4));
    send_sample(sample_t'(-3));

    // random phases: corner lengths first, then a mix weighted to short windows
    target = sent + RANDOM_REQUESTS;
    phase  = 0;
    while (sent < target) begin
      drain();
      case (phase)
        0: len = len_t'(WINDOW_MAX);
        1: len = len_t'(127);
        2: len = len_t'(1);
        3: len = len_t'(0);
        4: len = len_t'(WINDOW_MAX + 1);
        5: len = len_t'(2);
        6: len = len_t'(1);
        default: begin
          if ($urandom_range(0, 3) == 0) len = len_t'($urandom_range(0, 127));
          else if ($urandom_range(0, 1) == 0) len = len_t'($urandom_range(1, WINDOW_MAX));
          else len = len_t'($urandom_range(1, 8));
        end
      endcase
      set_window(len);
      if (phase == 6) begin
        // receiver holds off while requests keep coming back to back
        hold_request = HOLD_CYCLES;
        tx_quiet     = 1'b1;
        repeat (40) send_sample(random_sample());
        tx_quiet     = 1'b0;
      end else begin
        span_len = (len == 0) ? 1 : ((len > WINDOW_MAX) ? WINDOW_MAX : int'(len));
        count    = span_len - 1 + $urandom_range(8, 60);
        repeat (count) send_sample(random_sample());
      end
      phase++;
    end

    drain();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("[simple_moving_average] OK");
    end else begin
      $display("[simple_moving_average] ERROR");
    end
    $finish;
  end

endmodule
